// ===== src/tbag_pkg.sv =====
// Shared types and constants of the tile blit address generator.
`default_nettype none
package tbag_pkg;

  // Geometry of the tile grid and the plane.
  localparam int TILE_SIZE  = 16;
  localparam int ROW_PIXELS = 288;
  localparam int TILE_ROWS  = 15;

  // Width of the signed bit offsets; holds every offset the input ranges can produce.
  localparam int OFF_W  = 20;
  localparam int ADDR_W = 24;

  // Byte distance from the first to the last row of a tile, plus one word.
  localparam int DESC_ADJ = ROW_PIXELS * (TILE_SIZE - 1) / 8 + 2;

  localparam logic [31:0] MASK_ASC  = 32'hffff0000;
  localparam logic [31:0] MASK_DESC = 32'h0000ffff;

  // Configuration register indexes.
  localparam logic REG_ROTATION = 1'b0;
  localparam logic REG_ZOOM     = 1'b1;

  typedef struct packed {
    logic signed [1:0] rotation_mode;
    logic signed [1:0] zoom_mode;
  } mode_cfg_t;

  typedef struct packed {
    logic [4:0]        tile_column;
    logic [3:0]        tile_row;
    logic [3:0]        shift_x;
    logic [3:0]        shift_y;
    logic [ADDR_W-1:0] source_base;
    logic [ADDR_W-1:0] dest_base;
  } tile_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] source_pointer;
    logic [ADDR_W-1:0] dest_pointer;
    logic [15:0]       control_word;
    logic              descending;
    logic [15:0]       first_word_mask;
    logic [15:0]       last_word_mask;
  } blit_cmd_t;

endpackage
`default_nettype wire

// ===== src/tile_blit_address_generator_top.sv =====
// Top level of the tile blit address generator: request and result registers around the command logic.
// Each accepted tile request yields exactly one blit command. The request is held in the request
// register while the single combinational stage between the two registers computes its command,
// and the command is then loaded into the result register, from which it is valid on the result
// port; a stalled result register holds the request in the request register. A new request is
// taken in every cycle while results are consumed. When the result register is stalled, the request
// register still fills once, so one further request is taken before in_tready drops. Rotation and
// zoom modes are written through the APB-style port at byte addresses 0 and 4 and take effect for
// requests computed after the write.
`default_nettype none
module tile_blit_address_generator_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic      [31:0]  cfg_prdata,
  output logic              cfg_pready,
  // Tile requests
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tile_column[4:0], tile_row[8:5], shift_x[12:9], shift_y[16:13],
  // source_base[40:17], dest_base[64:41], zero[71:65]
  input  wire logic [71:0]  in_tdata,
  // Blit commands
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // source_pointer[23:0], dest_pointer[47:24], control_word[63:48], descending[64],
  // first_word_mask[80:65], last_word_mask[96:81], zero[103:97]
  output logic      [103:0] out_tdata
);

  tbag_pkg::mode_cfg_t mode_cfg;
  tbag_pkg::tile_req_t req_r, req_nxt;
  tbag_pkg::blit_cmd_t cmd, cmd_r;
  logic                req_valid_r, req_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_open;
  logic                advance;
  logic                in_fire;

  tbag_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mode_cfg    (mode_cfg)
  );

  tbag_cmd_logic u_cmd (
    .req      (req_r),
    .mode_cfg (mode_cfg),
    .cmd      (cmd)
  );

  assign out_open  = !out_valid_r || out_tready;
  assign advance   = req_valid_r && out_open;
  assign in_tready = !req_valid_r || out_open;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    req_nxt.tile_column = in_tdata[4:0];
    req_nxt.tile_row    = in_tdata[8:5];
    req_nxt.shift_x     = in_tdata[12:9];
    req_nxt.shift_y     = in_tdata[16:13];
    req_nxt.source_base = in_tdata[40:17];
    req_nxt.dest_base   = in_tdata[64:41];

    req_valid_nxt = in_fire || (req_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= req_nxt;
    end
    if (advance) begin
      cmd_r <= cmd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, cmd_r.last_word_mask, cmd_r.first_word_mask, cmd_r.descending,
                       cmd_r.control_word, cmd_r.dest_pointer, cmd_r.source_pointer};

  // A request moving into the result stage must show up as a valid result.
  a_advance_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("request advanced but no result became valid");

  // The descending flag and its copy in the control word must agree.
  a_desc_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[64] == out_tdata[49]))
    else $error("descending flag disagrees with control word");

  // Only the shift magnitude and the descending bit may be set in the control word.
  a_ctrl_spare: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[59:50] == 10'b0 && out_tdata[48] == 1'b0))
    else $error("spare control word bits set");

  // The rotated mask always covers exactly half of the two words.
  a_mask_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($countones(out_tdata[96:65]) == 16))
    else $error("word masks do not cover sixteen bits");

  // A full request register with a stalled result must hold off new requests.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("request accepted while both stages are full");

endmodule
`default_nettype wire

// ===== src/tbag_regs.sv =====
// Configuration registers of the tile blit address generator behind an APB-style port.
`default_nettype none
module tbag_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready,
  output tbag_pkg::mode_cfg_t    mode_cfg
);

  tbag_pkg::mode_cfg_t mode_r;
  tbag_pkg::mode_cfg_t mode_nxt;
  logic                wr_en;
  logic                reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    mode_nxt = mode_r;
    if (wr_en) begin
      case (reg_sel)
        tbag_pkg::REG_ROTATION: mode_nxt.rotation_mode = cfg_pwdata[1:0];
        tbag_pkg::REG_ZOOM:     mode_nxt.zoom_mode     = cfg_pwdata[1:0];
        default:                mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r.rotation_mode <= 2'sb01;
      mode_r.zoom_mode     <= 2'sb01;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      tbag_pkg::REG_ROTATION: cfg_prdata = {30'b0, mode_r.rotation_mode};
      tbag_pkg::REG_ZOOM:     cfg_prdata = {30'b0, mode_r.zoom_mode};
      default:                cfg_prdata = 32'b0;
    endcase
  end

  assign mode_cfg = mode_r;

endmodule
`default_nettype wire

// ===== src/tbag_cmd_logic.sv =====
// Combinational computation of one tile's blit command from its position and shift.
`default_nettype none
module tbag_cmd_logic (
  input  wire tbag_pkg::tile_req_t req,
  input  wire tbag_pkg::mode_cfg_t mode_cfg,
  output tbag_pkg::blit_cmd_t      cmd
);

  localparam int OW = tbag_pkg::OFF_W;
  localparam int AW = tbag_pkg::ADDR_W;

  logic signed [OW-1:0] col_e, row_e, shx_e, shy_e;
  logic signed [OW-1:0] dx, dy, xo, yo;
  logic signed [OW-1:0] sx_rot, sy_rot, sx, sy;
  logic signed [OW-1:0] shift_off, soff, doff, sq, dq;
  logic        [AW-1:0] sp_base, dp_base, adj;
  logic        [3:0]    sbit, dbit, mag;
  logic                 desc;
  logic        [31:0]   mask;
  logic        [63:0]   mask_dbl;
  logic        [31:0]   mask_rot;

  always_comb begin
    col_e = OW'(req.tile_column);
    row_e = OW'(req.tile_row);
    shx_e = OW'(req.shift_x);
    shy_e = OW'(req.shift_y);

    dx = OW'(col_e * tbag_pkg::TILE_SIZE);
    dy = OW'(row_e * tbag_pkg::TILE_SIZE);
    xo = col_e - OW'(tbag_pkg::TILE_SIZE / 2);
    yo = OW'(tbag_pkg::TILE_ROWS - tbag_pkg::TILE_SIZE / 2) - row_e;

    // A negative register value of either code acts as minus one.
    if (mode_cfg.rotation_mode[1]) begin
      sx_rot = dx - yo;
      sy_rot = dy - xo;
    end else if (mode_cfg.rotation_mode[0]) begin
      sx_rot = dx + yo;
      sy_rot = dy + xo;
    end else begin
      sx_rot = dx;
      sy_rot = dy;
    end

    if (mode_cfg.zoom_mode[1]) begin
      sx = sx_rot + xo;
      sy = sy_rot - yo;
    end else if (mode_cfg.zoom_mode[0]) begin
      sx = sx_rot - xo;
      sy = sy_rot + yo;
    end else begin
      sx = sx_rot;
      sy = sy_rot;
    end

    shift_off = OW'(shy_e * tbag_pkg::ROW_PIXELS) + shx_e;
    soff      = OW'(sy * tbag_pkg::ROW_PIXELS) + sx + shift_off;
    doff      = OW'(dy * tbag_pkg::ROW_PIXELS) + dx + shift_off;

    // Arithmetic shift gives the byte offset rounded toward minus infinity.
    sq = (soff >>> 3) & ~OW'(1);
    dq = (doff >>> 3) & ~OW'(1);
    sp_base = req.source_base + AW'(sq);
    dp_base = req.dest_base + AW'(dq);

    sbit = soff[3:0];
    dbit = doff[3:0];
    desc = dbit < sbit;
    mag  = desc ? (sbit - dbit) : (dbit - sbit);
    adj  = AW'(tbag_pkg::DESC_ADJ);

    mask     = desc ? tbag_pkg::MASK_DESC : tbag_pkg::MASK_ASC;
    mask_dbl = {mask, mask} >> dbit;
    mask_rot = mask_dbl[31:0];

    cmd.source_pointer  = desc ? (sp_base + adj) : sp_base;
    cmd.dest_pointer    = desc ? (dp_base + adj) : dp_base;
    cmd.control_word    = {mag, 10'b0, desc, 1'b0};
    cmd.descending      = desc;
    cmd.first_word_mask = mask_rot[31:16];
    cmd.last_word_mask  = mask_rot[15:0];
  end

endmodule
`default_nettype wire
